@@ src/pwlvr_pkg.sv @@
package pwlvr_pkg;

  // Table geometry
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);

  // Quotient of one interpolation step: magnitude never exceeds one level span
  localparam int unsigned QW     = 8;
  localparam int unsigned QCntW  = $clog2(QW);
  localparam int unsigned DenW   = 32;
  localparam int unsigned ProdW  = DenW + QW;

  // Voxel kinds
  localparam logic [2:0] KindU8  = 3'd0;
  localparam logic [2:0] KindS8  = 3'd1;
  localparam logic [2:0] KindU16 = 3'd2;
  localparam logic [2:0] KindS16 = 3'd3;
  localparam logic [2:0] KindS32 = 3'd4;

  // Commands
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdMap   = 1'b1;

  // Register indexes
  localparam logic [1:0] CfgKind  = 2'd0;
  localparam logic [1:0] CfgSwap  = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;

  // Search token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic        below;
    logic        above;
    logic        hit;
    logic [31:0] v;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [7:0]  l0;
    logic [7:0]  l1;
    logic [7:0]  lfirst;
    logic [7:0]  llast;
  } tok_t;

  // Swap and extend one voxel word
  function automatic logic [31:0] decode_voxel(logic [31:0] word, logic [2:0] kind,
                                               logic swap);
    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] h;
    logic [31:0] x;
    logic [31:0] r;
    b0 = word[7:0];
    b1 = word[15:8];
    b2 = word[23:16];
    b3 = word[31:24];
    h  = swap ? {b0, b1} : {b1, b0};
    x  = swap ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    unique case (kind)
      KindS8:  r = {{24{b0[7]}}, b0};
      KindU16: r = {16'b0, h};
      KindS16: r = {{16{h[15]}}, h};
      KindS32: r = x;
      default: r = {24'b0, b0};
    endcase
    return r;
  endfunction

endpackage

@@ src/pwlvr_cell.sv @@
module pwlvr_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [pwlvr_pkg::IdxW-1:0]     idx_i,
  input  logic [pwlvr_pkg::IdxW-1:0]     last_i,
  input  logic                           wr_en_i,
  input  logic [pwlvr_pkg::IdxW-1:0]     wr_idx_i,
  input  logic [31:0]                    wr_raw_i,
  input  logic [7:0]                     wr_level_i,
  input  logic [31:0]                    nxt_raw_i,
  input  logic [7:0]                     nxt_level_i,
  input  pwlvr_pkg::tok_t                tok_i,
  output pwlvr_pkg::tok_t                tok_o,
  output logic [31:0]                    raw_o,
  output logic [7:0]                     level_o
);

  logic [31:0]     raw_q;
  logic [7:0]      level_q;
  pwlvr_pkg::tok_t tok_d, tok_q;

  // Hold this cell's breakpoint
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i == idx_i) begin
      raw_q   <= wr_raw_i;
      level_q <= wr_level_i;
    end
  end

  // Update the token with this cell's verdict
  always_comb begin
    tok_d = tok_i;
    if (idx_i == '0) begin
      tok_d.below  = $signed(tok_i.v) < $signed(raw_q);
      tok_d.lfirst = level_q;
    end
    if (idx_i == last_i) begin
      tok_d.above = $signed(tok_i.v) > $signed(raw_q);
      tok_d.llast = level_q;
    end
    if (idx_i < last_i && $signed(tok_i.v) >= $signed(raw_q)
        && $signed(tok_i.v) <= $signed(nxt_raw_i)) begin
      tok_d.hit = 1'b1;
      tok_d.r0  = raw_q;
      tok_d.r1  = nxt_raw_i;
      tok_d.l0  = level_q;
      tok_d.l1  = nxt_level_i;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign raw_o   = raw_q;
  assign level_o = level_q;

endmodule

@@ src/pwlvr_div.sv @@
module pwlvr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pwlvr_pkg::ProdW-1:0]  num_i,
  input  logic [pwlvr_pkg::DenW-1:0]   den_i,
  output logic                         done_o,
  output logic [pwlvr_pkg::QW-1:0]     q_o
);

  logic [pwlvr_pkg::ProdW-1:0] rem_q, sh;
  logic [pwlvr_pkg::DenW-1:0]  den_q;
  logic [pwlvr_pkg::QW-1:0]    q_q;
  logic [pwlvr_pkg::QCntW-1:0] cnt_q;
  logic                        run_q, done_q;

  // Divisor aligned to the current quotient bit
  assign sh = {{pwlvr_pkg::QW{1'b0}}, den_q} << cnt_q;

  // Restoring division, one quotient bit a cycle, top bit first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= pwlvr_pkg::QCntW'(pwlvr_pkg::QW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      q_q   <= '0;
    end else if (run_q && rem_q >= sh) begin
      rem_q        <= rem_q - sh;
      q_q[cnt_q]   <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

@@ src/piecewise_linear_voxel_remap_top.sv @@
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  command, point_index, point_raw,
//                                              point_level, voxel_word
// out      output     out_valid_o / out_ready_i decoded_value, mapped_level
// cfg      input      cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// A breakpoint write is stored in its cell when accepted. A voxel passes through the
// chain of breakpoint cells, then through the 8-step divider when it is
// interpolated, and is then loaded into the output register.
// One voxel is in flight at a time; a full output register stalls the block.
// Reset clears control and resets the configuration registers; the breakpoint table is undefined until
// written.
module piecewise_linear_voxel_remap_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [3:0]  point_index_i,
  input  logic signed [31:0] point_raw_i,
  input  logic [7:0]  point_level_i,
  input  logic [31:0] voxel_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] decoded_value_o,
  output logic [7:0]  mapped_level_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i
);

  localparam int unsigned N = pwlvr_pkg::MaxPoints;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [2:0] kind_q;
  logic       swap_q;
  logic [4:0] count_q;

  logic [pwlvr_pkg::IdxW-1:0] last;
  logic                       accept, wr_en, map_go;
  pwlvr_pkg::tok_t            inj, te;
  pwlvr_pkg::tok_t            toks [N];
  logic [31:0]                raws [N];
  logic [7:0]                 levels [N];
  logic [N-1:0]               tok_vld;

  logic [31:0] dec_q, diff, den;
  logic [7:0]  l0_q, lvl_q, mag, q;
  logic        neg_q, neg, div_start, div_done, out_valid_q, load;
  logic [pwlvr_pkg::ProdW-1:0] prod;
  logic [31:0] out_dec_q;
  logic [7:0]  out_lvl_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= pwlvr_pkg::KindU8;
      swap_q  <= 1'b0;
      count_q <= 5'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwlvr_pkg::CfgKind:  kind_q  <= cfg_wdata_i[2:0];
        pwlvr_pkg::CfgSwap:  swap_q  <= cfg_wdata_i[0];
        pwlvr_pkg::CfgCount: count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the point count to the table
  always_comb begin
    priority if (count_q < 5'd2) begin
      last = pwlvr_pkg::IdxW'(1);
    end else if (count_q > pwlvr_pkg::CntW'(N)) begin
      last = pwlvr_pkg::IdxW'(N - 1);
    end else begin
      last = pwlvr_pkg::IdxW'(count_q - 5'd1);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && command_i == pwlvr_pkg::CmdWrite;
  assign map_go     = accept && command_i == pwlvr_pkg::CmdMap;

  // Inject a fresh token for each voxel
  always_comb begin
    inj     = '0;
    inj.vld = map_go;
    inj.v   = pwlvr_pkg::decode_voxel(voxel_word_i, kind_q, swap_q);
  end

  // Chain of breakpoint cells
  for (genvar m = 0; m < N; m++) begin : g_cell
    logic [31:0] nraw;
    logic [7:0]  nlvl;
    if (m < N - 1) begin : g_nb
      assign nraw = raws[m+1];
      assign nlvl = levels[m+1];
    end else begin : g_end
      assign nraw = raws[m];
      assign nlvl = levels[m];
    end
    pwlvr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (pwlvr_pkg::IdxW'(m)),
      .last_i      (last),
      .wr_en_i     (wr_en),
      .wr_idx_i    (point_index_i),
      .wr_raw_i    (point_raw_i),
      .wr_level_i  (point_level_i),
      .nxt_raw_i   (nraw),
      .nxt_level_i (nlvl),
      .tok_i       ((m == 0) ? inj : toks[(m == 0) ? 0 : m-1]),
      .tok_o       (toks[m]),
      .raw_o       (raws[m]),
      .level_o     (levels[m])
    );
    assign tok_vld[m] = toks[m].vld;
  end

  assign te = toks[N-1];

  // Interpolation operands: span, level step and product
  always_comb begin
    diff = te.v - te.r0;
    den  = te.r1 - te.r0;
    neg  = te.l1 < te.l0;
    mag  = neg ? (te.l0 - te.l1) : (te.l1 - te.l0);
    prod = pwlvr_pkg::ProdW'(diff) * pwlvr_pkg::ProdW'(mag);
  end

  assign div_start = (state_q == ST_SCAN) && te.vld && !te.below && !te.above
                     && te.hit && den != '0;

  pwlvr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (den),
    .done_o  (div_done),
    .q_o     (q)
  );

  assign load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (map_go) state_d = ST_SCAN;
      ST_SCAN: if (te.vld) state_d = div_start ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_done) state_d = ST_FIN;
      ST_FIN:  if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pick the level once the token leaves the chain
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && te.vld) begin
      dec_q <= te.v;
      l0_q  <= te.l0;
      neg_q <= neg;
      priority if (te.below) begin
        lvl_q <= te.lfirst;
      end else if (te.above || !te.hit) begin
        lvl_q <= te.llast;
      end else begin
        lvl_q <= te.l0;
      end
    end else if (state_q == ST_DIV && div_done) begin
      lvl_q <= neg_q ? (l0_q - q) : (l0_q + q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_dec_q <= dec_q;
      out_lvl_q <= lvl_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_value_o = out_dec_q;
  assign mapped_level_o  = out_lvl_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one voxel in the cell chain");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    te.vld |-> state_q == ST_SCAN)
    else $error("token left the chain outside the scan");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_load_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && state_q == ST_IDLE)
    else $error("output load did not complete");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pwlvr_pkg::*;

  localparam int unsigned RandItems = 1450;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic              command;
    logic [3:0]        point_index;
    logic signed [31:0] point_raw;
    logic [7:0]        point_level;
    logic [31:0]       voxel_word;
  } voxel_cmd_t;

  typedef struct packed {
    logic signed [31:0] decoded_value;
    logic [7:0]         mapped_level;
  } voxel_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              command_i = 1'b0;
  logic [3:0]        point_index_i = '0;
  logic signed [31:0] point_raw_i = '0;
  logic [7:0]        point_level_i = '0;
  logic [31:0]       voxel_word_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [31:0] decoded_value_o;
  logic [7:0]        mapped_level_o;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [4:0]        cfg_wdata_i = '0;

  piecewise_linear_voxel_remap_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic signed [31:0] pred_raws [MaxPoints];
  logic [7:0]         pred_levels [MaxPoints];
  logic [2:0]         pred_kind = KindU8;
  logic               pred_swap = 1'b0;
  logic [4:0]         pred_count = 5'd2;

  voxel_cmd_t pending_cmds [$];
  voxel_res_t expected_levels [$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          hold_sender = 1'b0;
  bit          long_stall_req = 1'b0;
  bit          stim_done = 1'b0;
  bit          in_taken = 1'b0;

  function automatic logic signed [31:0] predict_decode(logic [31:0] w);
    logic [15:0] h;
    h = pred_swap ? {w[7:0], w[15:8]} : w[15:0];
    case (pred_kind)
      KindS8:  return {{24{w[7]}}, w[7:0]};
      KindU16: return {16'b0, h};
      KindS16: return {{16{h[15]}}, h};
      KindS32: return pred_swap ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
      default: return {24'b0, w[7:0]};
    endcase
  endfunction

  function automatic logic [7:0] predict_level(logic signed [31:0] v);
    int unsigned n;
    int unsigned last;
    longint r0, r1, l0, l1, q;
    logic [7:0] lvl;
    n = pred_count;
    if (n < 2) n = 2;
    if (n > MaxPoints) n = MaxPoints;
    last = n - 1;
    if (v < pred_raws[0]) return pred_levels[0];
    if (v > pred_raws[last]) return pred_levels[last];
    lvl = pred_levels[last];
    for (int unsigned m = 0; m < last; m++) begin
      r0 = pred_raws[m];
      r1 = pred_raws[m + 1];
      if (longint'(v) >= r0 && longint'(v) <= r1) begin
        l0 = pred_levels[m];
        l1 = pred_levels[m + 1];
        q = 0;
        if (r1 != r0) q = ((longint'(v) - r0) * (l1 - l0)) / (r1 - r0);
        lvl = 8'(l0 + q);
      end
    end
    return lvl;
  endfunction

  // Fold one accepted item into the predictor
  function automatic void predict_item(voxel_cmd_t c);
    voxel_res_t r;
    if (c.command == CmdWrite) begin
      pred_raws[c.point_index] = c.point_raw;
      pred_levels[c.point_index] = c.point_level;
    end else begin
      r.decoded_value = predict_decode(c.voxel_word);
      r.mapped_level = predict_level(r.decoded_value);
      expected_levels.push_back(r);
    end
  endfunction

  function automatic voxel_cmd_t map_cmd(logic [31:0] w);
    voxel_cmd_t c;
    c = '0;
    c.command = CmdMap;
    c.point_index = 4'($urandom);
    c.point_raw = $urandom;
    c.point_level = 8'($urandom);
    c.voxel_word = w;
    return c;
  endfunction

  function automatic voxel_cmd_t point_cmd(logic [3:0] idx, logic signed [31:0] raw,
                                           logic [7:0] lvl);
    voxel_cmd_t c;
    c.command = CmdWrite;
    c.point_index = idx;
    c.point_raw = raw;
    c.point_level = lvl;
    c.voxel_word = $urandom;
    return c;
  endfunction

  // Random voxel word, often near a breakpoint of the current table
  function automatic logic [31:0] pick_word(int unsigned n);
    logic [31:0] w;
    int unsigned k;
    k = $urandom_range(n - 1);
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = pred_raws[k] + 32'($urandom_range(6)) - 32'd3;
      2: w = {$urandom_range(1) ? 24'hffffff : 24'h0, 8'($urandom)};
      default: w = pred_raws[k] + ((pred_raws[(k + 1) % n] - pred_raws[k]) >>> 1);
    endcase
    if (pred_swap && pred_kind != KindU8 && pred_kind != KindS8 && $urandom_range(1))
      w = {w[7:0], w[15:8], w[23:16], w[31:24]};
    return w;
  endfunction

  // Load an ascending table into all MaxPoints cells, spread for n points and scaled to the current kind
  task automatic load_table(int unsigned n, int unsigned span_bits);
    logic signed [31:0] raw;
    raw = -(32'sd1 <<< (span_bits - 1));
    for (int unsigned i = 0; i < MaxPoints; i++) begin
      if (i != 0 && $urandom_range(9) != 0)
        raw = raw + 32'($urandom_range((1 << (span_bits - 4)) / n + 1));
      pending_cmds.push_back(point_cmd(4'(i), raw, 8'($urandom)));
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid_i || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgKind:  pred_kind = val[2:0];
      CfgSwap:  pred_swap = val[0];
      default:  pred_count = val;
    endcase
  endtask

  // Stimulus
  initial begin
    int unsigned n, bits, cnt;
    logic [2:0] kind;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full table, kinds U8, S32, S16, U16 and an unused code, extremes, flat span, non-ascending table
    for (int unsigned i = 0; i < MaxPoints; i++)
      pending_cmds.push_back(point_cmd(4'(i), 32'sd16 * i - 32'sd8, 8'(i * 17)));
    pending_cmds.push_back(point_cmd(4'd15, 32'sh7fffffff, 8'hff));
    pending_cmds.push_back(point_cmd(4'd0, 32'sh80000000, 8'h00));
    pending_cmds.push_back(map_cmd(32'h0000_00ff));
    pending_cmds.push_back(map_cmd(32'hffff_ff00));
    wait_drained();
    write_reg(CfgCount, 5'd16);
    write_reg(CfgKind, KindS32);
    pending_cmds.push_back(map_cmd(32'h8000_0000));
    pending_cmds.push_back(map_cmd(32'h7fff_ffff));
    pending_cmds.push_back(point_cmd(4'd3, 32'sd24, 8'd200));
    pending_cmds.push_back(point_cmd(4'd4, 32'sd24, 8'd10));
    pending_cmds.push_back(map_cmd(32'd24));
    pending_cmds.push_back(point_cmd(4'd5, -32'sd500, 8'd90));
    pending_cmds.push_back(map_cmd(32'd60));
    pending_cmds.push_back(map_cmd(32'hffff_fff9));
    wait_drained();
    write_reg(CfgCount, 5'd0);
    write_reg(CfgSwap, 1'b1);
    pending_cmds.push_back(map_cmd(32'h1234_5678));
    wait_drained();
    write_reg(CfgKind, 3'd7);
    pending_cmds.push_back(map_cmd(32'h1234_5680));
    wait_drained();
    write_reg(CfgCount, 5'd31);
    write_reg(CfgKind, KindS16);
    pending_cmds.push_back(map_cmd(32'h0000_0080));
    wait_drained();
    write_reg(CfgKind, KindU16);
    pending_cmds.push_back(map_cmd(32'h0000_ffff));
    wait_drained();

    // Random phases with fresh settings
    cnt = 0;
    while (cnt < RandItems) begin
      kind = 3'($urandom_range(7));
      n = $urandom_range(4) == 0 ? ($urandom_range(1) ? 2 : 16) : $urandom_range(2, 16);
      write_reg(CfgKind, kind);
      write_reg(CfgSwap, 1'($urandom));
      write_reg(CfgCount, 5'(n));
      case (kind)
        KindS8, KindU8: bits = 9;
        KindU16, KindS16: bits = 17;
        KindS32: bits = 32;
        default: bits = 9;
      endcase
      load_table(n, bits);
      cnt += MaxPoints;
      for (int unsigned i = 0; i < 120; i++) begin
        if ($urandom_range(15) == 0)
          pending_cmds.push_back(point_cmd(4'($urandom), $urandom, 8'($urandom)));
        else
          pending_cmds.push_back(map_cmd(pick_word(n)));
      end
      cnt += 120;
      // Two phases with a long receiver hold-off, one with a paused sender
      if (cnt < 300) long_stall_req = 1'b1;
      if (cnt > 600 && cnt < 760) begin
        while (pending_cmds.size() > 40) @(posedge clk_i);
        hold_sender = 1'b1;
        while (expected_levels.size() != 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_drained();
    end
    stim_done = 1'b1;
  end

  // Note whether the offered item was taken at the last rising edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
  end

  // Driver
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() != 0 && !hold_sender &&
                   !(in_valid_i && in_taken)) begin
        in_valid_i <= 1'b1;
        {command_i, point_index_i, point_raw_i, point_level_i, voxel_word_i}
          <= pending_cmds.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        if (in_valid_i && $urandom_range(3) == 0)
          send_gap <= $urandom_range(9) == 0 ? $urandom_range(60) : $urandom_range(3);
      end
    end
  end

  // Receiver readiness
  int unsigned recv_hold = 0;
  always @(negedge clk_i) begin
    if (long_stall_req && recv_hold == 0) begin
      long_stall_req <= 1'b0;
      recv_hold <= 400;
      out_ready_i <= 1'b0;
    end else if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      recv_hold <= $urandom_range(9) == 0 ? $urandom_range(80) : $urandom_range(3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: accept items, predict and check
  always @(posedge clk_i) begin
    voxel_res_t exp_r;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        predict_item({command_i, point_index_i, point_raw_i, point_level_i, voxel_word_i});
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_levels.size() == 0) begin
          $error("unexpected item: decoded_value %0d mapped_level %0d",
                 decoded_value_o, mapped_level_o);
          fail_count++;
        end else begin
          exp_r = expected_levels.pop_front();
          if (decoded_value_o !== exp_r.decoded_value) begin
            $error("decoded_value expected %0d actual %0d",
                   exp_r.decoded_value, decoded_value_o);
            fail_count++;
          end
          if (mapped_level_o !== exp_r.mapped_level) begin
            $error("mapped_level expected %0d actual %0d",
                   exp_r.mapped_level, mapped_level_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Finish on completion or on a stalled run
  initial begin
    while (!stim_done && idle_cycles < IdleLimit) @(posedge clk_i);
    if (idle_cycles >= IdleLimit) begin
      $display("[piecewise_linear_voxel_remap_top] ERROR");
    end else begin
      if (expected_levels.size() != 0) fail_count++;
      if (fail_count == 0)
        $display("[piecewise_linear_voxel_remap_top] OK");
      else
        $display("[piecewise_linear_voxel_remap_top] ERROR");
    end
    $finish;
  end

endmodule
